[sv/jet_pkg.sv]
// ----------------------------------------------------------------------------
// jet_pkg
// Shared types, register indexes and fixed-point helpers for the Julia set
// escape-time block.
// ----------------------------------------------------------------------------
package jet_pkg;

  localparam int Q_FRAC      = 28;
  localparam int DATA_W      = 32;
  localparam int COUNT_W     = 12;
  localparam int PIXEL_W     = 10;
  localparam int CFG_INDEX_W = 3;
  localparam int QUEUE_DEPTH = 2;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_REAL   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_REAL   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_IMAG   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_IMAG   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SEED_REAL  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SEED_IMAG  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_ITER_LIMIT = 3'd6;

  // |z|^2 bound of 4 in Q8.56
  localparam logic [63:0] ESCAPE_BOUND = 64'd4 << (2 * Q_FRAC);

  typedef struct packed {
    logic signed [DATA_W-1:0] min_re;
    logic signed [DATA_W-1:0] max_re;
    logic signed [DATA_W-1:0] min_im;
    logic signed [DATA_W-1:0] max_im;
  } view_cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] seed_re;
    logic signed [DATA_W-1:0] seed_im;
    logic [COUNT_W-1:0]       limit;
  } iter_cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } coord_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [65:0] v);
    logic signed [DATA_W-1:0] r;
    if (v > 66'sd2147483647) r = 32'sh7FFF_FFFF;
    else if (v < -66'sd2147483648) r = 32'sh8000_0000;
    else r = v[DATA_W-1:0];
    return r;
  endfunction

endpackage

[sv/jet_queue.sv]
// ----------------------------------------------------------------------------
// jet_queue
// Short queue of mapped start points between the front and back ends.
// ----------------------------------------------------------------------------
module jet_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  jet_pkg::coord_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output jet_pkg::coord_t out_data
);

  localparam int PTR_W = $clog2(jet_pkg::QUEUE_DEPTH);

  jet_pkg::coord_t           entries [jet_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]          wr_ptr;
  logic [PTR_W-1:0]          rd_ptr;
  logic [PTR_W:0]            count;
  logic                      push;
  logic                      pop;

  assign in_ready  = (count != (PTR_W+1)'(jet_pkg::QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign push      = in_valid & in_ready;
  assign pop       = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= in_data;
  end

endmodule

[sv/jet_front.sv]
// ----------------------------------------------------------------------------
// jet_front
// Takes a pixel, divides both view spans by the image size (multiply by a
// constant reciprocal) and maps the pixel to a saturated Q4.28 start point.
// ----------------------------------------------------------------------------
module jet_front #(
  parameter int IMAGE_WIDTH  = 1024,
  parameter int IMAGE_HEIGHT = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  jet_pkg::view_cfg_t           view,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [jet_pkg::PIXEL_W-1:0]  pixel_x,
  input  logic [jet_pkg::PIXEL_W-1:0]  pixel_y,
  output logic                         q_valid,
  input  logic                         q_ready,
  output jet_pkg::coord_t              q_data
);

  localparam int DW        = jet_pkg::DATA_W;
  localparam int PW        = jet_pkg::PIXEL_W;
  localparam int PROD_W    = PW + 1 + DW;
  // floor(m / D) == (m * RECIP) >> SHIFT for every 32-bit m when
  // SHIFT = 32 + ceil(log2 D) and RECIP = ceil(2^SHIFT / D)
  localparam int SHIFT_X   = DW + $clog2(IMAGE_WIDTH);
  localparam int SHIFT_Y   = DW + $clog2(IMAGE_HEIGHT);
  localparam logic [DW:0] RECIP_X =
    (DW+1)'(((64'd1 << SHIFT_X) + 64'(IMAGE_WIDTH) - 64'd1) / 64'(IMAGE_WIDTH));
  localparam logic [DW:0] RECIP_Y =
    (DW+1)'(((64'd1 << SHIFT_Y) + 64'(IMAGE_HEIGHT) - 64'd1) / 64'(IMAGE_HEIGHT));

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_DIV  = 2'd1;
  localparam logic [1:0] F_MAP  = 2'd2;
  localparam logic [1:0] F_PUSH = 2'd3;

  logic [1:0]              state;
  logic [PW-1:0]           px;
  logic [PW-1:0]           py;
  logic [DW-1:0]           dvd_re;
  logic [DW-1:0]           dvd_im;
  logic                    neg_re;
  logic                    neg_im;
  jet_pkg::coord_t         point;

  logic signed [DW:0]      diff_re;
  logic signed [DW:0]      diff_im;
  logic [DW:0]             mag_re;
  logic [DW:0]             mag_im;
  logic [2*DW:0]           rprod_re;
  logic [2*DW:0]           rprod_im;
  logic [DW-1:0]           quo_re;
  logic [DW-1:0]           quo_im;
  logic signed [DW-1:0]    step_re;
  logic signed [DW-1:0]    step_im;
  logic signed [PROD_W-1:0] prod_re;
  logic signed [PROD_W-1:0] prod_im;
  logic signed [PROD_W:0]  sum_re;
  logic signed [PROD_W:0]  sum_im;

  assign in_ready = (state == F_IDLE);
  assign q_valid  = (state == F_PUSH);
  assign q_data   = point;

  // spans, with magnitudes for the unsigned divide
  assign diff_re = (DW+1)'(view.max_re) - (DW+1)'(view.min_re);
  assign diff_im = (DW+1)'(view.max_im) - (DW+1)'(view.min_im);
  assign mag_re  = diff_re[DW] ? (DW+1)'(-diff_re) : diff_re;
  assign mag_im  = diff_im[DW] ? (DW+1)'(-diff_im) : diff_im;

  // span magnitude over image size
  assign rprod_re = (2*DW+1)'(dvd_re) * (2*DW+1)'(RECIP_X);
  assign rprod_im = (2*DW+1)'(dvd_im) * (2*DW+1)'(RECIP_Y);
  assign quo_re   = DW'(rprod_re >> SHIFT_X);
  assign quo_im   = DW'(rprod_im >> SHIFT_Y);

  // quotient truncates toward zero; sign reapplied
  assign step_re = neg_re ? -$signed(dvd_re) : $signed(dvd_re);
  assign step_im = neg_im ? -$signed(dvd_im) : $signed(dvd_im);
  assign prod_re = $signed({1'b0, px}) * step_re;
  assign prod_im = $signed({1'b0, py}) * step_im;
  assign sum_re  = (PROD_W+1)'(prod_re) + (PROD_W+1)'(view.min_re);
  assign sum_im  = (PROD_W+1)'(view.max_im) - (PROD_W+1)'(prod_im);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: if (in_valid) state <= F_DIV;
        F_DIV:  state <= F_MAP;
        F_MAP:  state <= F_PUSH;
        F_PUSH: if (q_ready) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      F_IDLE: begin
        px     <= pixel_x;
        py     <= pixel_y;
        dvd_re <= mag_re[DW-1:0];
        dvd_im <= mag_im[DW-1:0];
        neg_re <= diff_re[DW];
        neg_im <= diff_im[DW];
      end
      F_DIV: begin
        dvd_re <= quo_re;
        dvd_im <= quo_im;
      end
      F_MAP: begin
        point.re <= jet_pkg::sat32(66'(sum_re));
        point.im <= jet_pkg::sat32(66'(sum_im));
      end
      F_PUSH: ;
      default: ;
    endcase
  end

endmodule

[sv/jet_back.sv]
// ----------------------------------------------------------------------------
// jet_back
// Escape-time iteration of z = z^2 + c on one start point at a time, with
// the result held in an output register.
// ----------------------------------------------------------------------------
module jet_back (
  input  logic                         clk,
  input  logic                         rst,
  input  jet_pkg::iter_cfg_t           iter,
  input  logic                         q_valid,
  output logic                         q_ready,
  input  jet_pkg::coord_t              q_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [jet_pkg::COUNT_W-1:0]  escape_count,
  output logic                         inside_set
);

  localparam int DW = jet_pkg::DATA_W;
  localparam int CW = jet_pkg::COUNT_W;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_MUL  = 2'd1;
  localparam logic [1:0] B_UPD  = 2'd2;

  logic [1:0]            state;
  logic signed [DW-1:0]  z_re;
  logic signed [DW-1:0]  z_im;
  logic signed [63:0]    rr;
  logic signed [63:0]    ii;
  logic signed [63:0]    ri;
  logic [CW-1:0]         n;

  logic [63:0]           mag2;
  logic                  escaped;
  logic [CW-1:0]         n_inc;
  logic                  finish;
  logic [CW-1:0]         n_final;
  logic                  out_free;
  logic                  load_out;
  logic signed [63:0]    diff;
  logic signed [DW-1:0]  re_sq;
  logic signed [DW-1:0]  im_sq;
  logic signed [DW-1:0]  re_next;
  logic signed [DW-1:0]  im_next;

  assign q_ready  = (state == B_IDLE);
  assign out_free = !out_valid || out_ready;
  assign load_out = (state == B_UPD) && finish && out_free;

  assign mag2    = $unsigned(rr) + $unsigned(ii);
  assign escaped = (mag2 >= jet_pkg::ESCAPE_BOUND);
  assign n_inc   = n + 1'b1;
  assign finish  = escaped || (n_inc >= iter.limit);
  assign n_final = escaped ? n : n_inc;

  assign diff    = rr - ii;
  assign re_sq   = jet_pkg::sat32(66'(diff >>> jet_pkg::Q_FRAC));
  assign im_sq   = jet_pkg::sat32(66'(ri >>> (jet_pkg::Q_FRAC - 1)));
  assign re_next = jet_pkg::sat32(66'(re_sq) + 66'(iter.seed_re));
  assign im_next = jet_pkg::sat32(66'(im_sq) + 66'(iter.seed_im));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: if (q_valid) state <= B_MUL;
        B_MUL:  state <= B_UPD;
        B_UPD: begin
          // a finished point waits here until the output register frees up
          if (!finish) state <= B_MUL;
          else if (out_free) state <= B_IDLE;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      B_IDLE: begin
        z_re <= q_data.re;
        z_im <= q_data.im;
        n    <= '0;
      end
      B_MUL: begin
        rr <= z_re * z_re;
        ii <= z_im * z_im;
        ri <= z_re * z_im;
      end
      B_UPD: begin
        if (!finish) begin
          z_re <= re_next;
          z_im <= im_next;
          n    <= n_inc;
        end else if (out_free) begin
          if (n_final == iter.limit) begin
            escape_count <= '0;
            inside_set   <= 1'b1;
          end else begin
            escape_count <= n_final;
            inside_set   <= 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

endmodule

[sv/julia_escape_time_top.sv]
// ----------------------------------------------------------------------------
// julia_escape_time_top
// Julia set escape-time engine: pixel in, escape count or inside flag out.
// ----------------------------------------------------------------------------
// The front end maps each pixel in order (capture the spans, divide both by
// the image size with a constant reciprocal multiply, scale and saturate, hand
// over), stalling only while the two-entry queue it feeds is full. The back end
// loads a point, then runs each iteration as a multiply state for the three
// registered 32x32 products and an update state for the escape test and z
// update; a finished point waits for the output register. The iteration limit
// is 50 at reset. The back end takes one point at a time, while the front end
// can map further pixels into the queue. Registers are written by the user
// through cfg_we/cfg_index/cfg_data only while no pixel is in flight; the block
// does not enforce this. An index beyond the list is ignored.
module julia_escape_time_top #(
  parameter int IMAGE_WIDTH  = 1024,
  parameter int IMAGE_HEIGHT = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [jet_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [jet_pkg::DATA_W-1:0]        cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [23:0]                       s_tdata,  // pixel_x, pixel_y, zero pad
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [15:0]                       m_tdata,  // escape_count, zero pad
  output logic                              m_tuser   // inside_set
);

  jet_pkg::view_cfg_t               view;
  jet_pkg::iter_cfg_t               iter;
  logic                             q_in_valid;
  logic                             q_in_ready;
  jet_pkg::coord_t                  q_in_data;
  logic                             q_out_valid;
  logic                             q_out_ready;
  jet_pkg::coord_t                  q_out_data;
  logic [jet_pkg::COUNT_W-1:0]      escape_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      view.min_re <= 32'shE000_0000;
      view.max_re <= 32'sh2000_0000;
      view.min_im <= 32'shE000_0000;
      view.max_im <= 32'sh2000_0000;
      iter.seed_re <= '0;
      iter.seed_im <= '0;
      iter.limit   <= 12'd50;
    end else if (cfg_we) begin
      unique case (cfg_index)
        jet_pkg::REG_MIN_REAL:   view.min_re  <= cfg_data;
        jet_pkg::REG_MAX_REAL:   view.max_re  <= cfg_data;
        jet_pkg::REG_MIN_IMAG:   view.min_im  <= cfg_data;
        jet_pkg::REG_MAX_IMAG:   view.max_im  <= cfg_data;
        jet_pkg::REG_SEED_REAL:  iter.seed_re <= cfg_data;
        jet_pkg::REG_SEED_IMAG:  iter.seed_im <= cfg_data;
        jet_pkg::REG_ITER_LIMIT: iter.limit   <= cfg_data[jet_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  jet_front #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .view     (view),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .pixel_x  (s_tdata[9:0]),
    .pixel_y  (s_tdata[19:10]),
    .q_valid  (q_in_valid),
    .q_ready  (q_in_ready),
    .q_data   (q_in_data)
  );

  jet_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_in_valid),
    .in_ready  (q_in_ready),
    .in_data   (q_in_data),
    .out_valid (q_out_valid),
    .out_ready (q_out_ready),
    .out_data  (q_out_data)
  );

  jet_back u_back (
    .clk          (clk),
    .rst          (rst),
    .iter         (iter),
    .q_valid      (q_out_valid),
    .q_ready      (q_out_ready),
    .q_data       (q_out_data),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .escape_count (escape_count),
    .inside_set   (m_tuser)
  );

  assign m_tdata = {4'b0, escape_count};

endmodule
